// ===== src/fltw_pkg.sv =====
// ----------------------------------------------------------------------------
// fltw_pkg
// shared constants, status codes and controller/datapath structs for the
// four-level page table walker
// ----------------------------------------------------------------------------
package fltw_pkg;

    // entry store geometry
    localparam int STORE_WORDS = 4096;
    localparam int ADDR_W      = $clog2(STORE_WORDS);
    localparam int INDEX_BITS  = 9;
    localparam int TABLE_WORDS = 1 << INDEX_BITS;
    localparam int LEVELS      = 4;

    // highest table frame whose 512 words all lie inside the store
    localparam int TABLE_LIMIT = (STORE_WORDS - TABLE_WORDS) / TABLE_WORDS;

    // field widths
    localparam int ENTRY_W     = 64;
    localparam int VA_W        = 48;
    localparam int PA_W        = 52;
    localparam int OFFSET_BITS = 12;
    localparam int FRAME_BITS  = PA_W - OFFSET_BITS;
    localparam int SIDX_W      = 12;
    localparam int STATUS_W    = 3;
    localparam int PRESENT_BIT = 0;

    // opcodes
    localparam logic OP_WRITE     = 1'b0;
    localparam logic OP_TRANSLATE = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] STAT_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_ABSENT_L1 = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_ABSENT_L2 = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_ABSENT_L3 = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_ABSENT_L4 = 3'd4;
    localparam logic [STATUS_W-1:0] STAT_OUTSIDE   = 3'd5;

    typedef logic [1:0] t_level;

    localparam t_level LAST_LEVEL = 2'(LEVELS - 1);

    // commands from controller to datapath
    typedef struct packed {
        logic                clear_en;
        logic                load_va;
        logic                wr_en;
        logic                rd_en;
        logic                rd_from_root;
        t_level              rd_level;
        logic                res_load;
        logic                res_use_frame;
        logic [STATUS_W-1:0] res_status;
    } t_ctrl_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic clear_last;
        logic root_outside;
        logic entry_present;
        logic next_outside;
    } t_dp_status;

endpackage

// ===== src/fltw_item_if.sv =====
// ----------------------------------------------------------------------------
// fltw_item_if
// input channel: entry write or translate request word
// ----------------------------------------------------------------------------
interface fltw_item_if
    import fltw_pkg::*;
();
    logic                valid;
    logic                ready;
    logic                opcode;
    logic [SIDX_W-1:0]   store_index;
    logic [ENTRY_W-1:0]  entry_value;
    logic [VA_W-1:0]     virt_addr;

    modport source (
        output valid, opcode, store_index, entry_value, virt_addr,
        input  ready
    );

    modport sink (
        input  valid, opcode, store_index, entry_value, virt_addr,
        output ready
    );
endinterface

// ===== src/fltw_result_if.sv =====
// ----------------------------------------------------------------------------
// fltw_result_if
// output channel: translated address and status word
// ----------------------------------------------------------------------------
interface fltw_result_if
    import fltw_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [PA_W-1:0]     phys_addr;
    logic [STATUS_W-1:0] status;

    modport source (
        output valid, phys_addr, status,
        input  ready
    );

    modport sink (
        input  valid, phys_addr, status,
        output ready
    );
endinterface

// ===== src/fltw_cfg_if.sv =====
// ----------------------------------------------------------------------------
// fltw_cfg_if
// configuration write channel for the root table register
// ----------------------------------------------------------------------------
interface fltw_cfg_if
    import fltw_pkg::*;
();
    logic            valid;
    logic            ready;
    logic [PA_W-1:0] root_table_address;

    modport source (
        output valid, root_table_address,
        input  ready
    );

    modport sink (
        input  valid, root_table_address,
        output ready
    );
endinterface

// ===== src/fltw_ctrl.sv =====
// ----------------------------------------------------------------------------
// fltw_ctrl
// walk sequencer: store clearing, request intake, level stepping and
// result register handshake
// ----------------------------------------------------------------------------
module fltw_ctrl
    import fltw_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_opcode,
    input  logic       i_out_ready,
    input  t_dp_status i_dp,
    output logic       o_in_ready,
    output logic       o_out_valid,
    output t_ctrl_cmd  o_cmd
);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_WALK  = 2'd2;

    logic [1:0] r_state, n_state;
    t_level     r_level, n_level;
    logic       r_out_valid, n_out_valid;
    logic       w_accept;
    t_ctrl_cmd  w_cmd;

    assign o_in_ready  = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign w_accept    = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_cmd       = w_cmd;

    always_comb begin
        n_state = r_state;
        n_level = r_level;
        w_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                w_cmd.clear_en = 1'b1;
                if (i_dp.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    w_cmd.load_va = 1'b1;
                    if (i_opcode == OP_WRITE) begin
                        w_cmd.wr_en      = 1'b1;
                        w_cmd.res_load   = 1'b1;
                        w_cmd.res_status = STAT_OK;
                    end else if (i_dp.root_outside) begin
                        w_cmd.res_load   = 1'b1;
                        w_cmd.res_status = STAT_OUTSIDE;
                    end else begin
                        w_cmd.rd_en        = 1'b1;
                        w_cmd.rd_from_root = 1'b1;
                        n_level            = '0;
                        n_state            = S_WALK;
                    end
                end
            end
            S_WALK: begin
                if (!i_dp.entry_present) begin
                    w_cmd.res_load = 1'b1;
                    case (r_level)
                        2'd0:    w_cmd.res_status = STAT_ABSENT_L1;
                        2'd1:    w_cmd.res_status = STAT_ABSENT_L2;
                        2'd2:    w_cmd.res_status = STAT_ABSENT_L3;
                        default: w_cmd.res_status = STAT_ABSENT_L4;
                    endcase
                    n_state = S_IDLE;
                end else if (r_level == LAST_LEVEL) begin
                    w_cmd.res_load      = 1'b1;
                    w_cmd.res_use_frame = 1'b1;
                    w_cmd.res_status    = STAT_OK;
                    n_state             = S_IDLE;
                end else if (i_dp.next_outside) begin
                    w_cmd.res_load   = 1'b1;
                    w_cmd.res_status = STAT_OUTSIDE;
                    n_state          = S_IDLE;
                end else begin
                    w_cmd.rd_en    = 1'b1;
                    w_cmd.rd_level = r_level + 2'd1;
                    n_level        = r_level + 2'd1;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_comb begin
        if (w_cmd.res_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_level     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_level     <= n_level;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ===== src/fltw_datapath.sv =====
// ----------------------------------------------------------------------------
// fltw_datapath
// entry store, root register, walk address generation and result payload
// ----------------------------------------------------------------------------
module fltw_datapath
    import fltw_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_ctrl_cmd           i_cmd,
    input  logic [SIDX_W-1:0]   i_store_index,
    input  logic [ENTRY_W-1:0]  i_entry_value,
    input  logic [VA_W-1:0]     i_va,
    input  logic                i_cfg_we,
    input  logic [PA_W-1:0]     i_cfg_root,
    output t_dp_status          o_status,
    output logic [PA_W-1:0]     o_phys_addr,
    output logic [STATUS_W-1:0] o_status_code
);

    logic [ENTRY_W-1:0]    mem [STORE_WORDS];
    logic [ENTRY_W-1:0]    r_rdata;
    logic [ADDR_W-1:0]     r_clr_addr;
    logic [FRAME_BITS-1:0] r_root_frame;
    logic [VA_W-1:0]       r_va;
    logic [PA_W-1:0]       r_pa;
    logic [STATUS_W-1:0]   r_status;

    logic [FRAME_BITS-1:0] w_entry_frame;
    logic [FRAME_BITS-1:0] w_rd_frame;
    logic [INDEX_BITS-1:0] w_rd_idx;
    logic [INDEX_BITS-1:0] w_walk_idx;
    logic [ADDR_W-1:0]     w_rd_addr;
    logic                  w_wr_ok;

    assign w_entry_frame = r_rdata[PA_W-1:OFFSET_BITS];

    // index bits of the latched address for levels two to four
    always_comb begin
        case (i_cmd.rd_level)
            2'd0:    w_walk_idx = r_va[OFFSET_BITS + 3*INDEX_BITS +: INDEX_BITS];
            2'd1:    w_walk_idx = r_va[OFFSET_BITS + 2*INDEX_BITS +: INDEX_BITS];
            2'd2:    w_walk_idx = r_va[OFFSET_BITS + INDEX_BITS +: INDEX_BITS];
            default: w_walk_idx = r_va[OFFSET_BITS +: INDEX_BITS];
        endcase
    end

    assign w_rd_frame = i_cmd.rd_from_root ? r_root_frame : w_entry_frame;
    assign w_rd_idx   = i_cmd.rd_from_root
                      ? i_va[OFFSET_BITS + 3*INDEX_BITS +: INDEX_BITS] : w_walk_idx;
    assign w_rd_addr  = ADDR_W'({w_rd_frame, w_rd_idx});
    assign w_wr_ok    = i_cmd.wr_en && (32'(i_store_index) < 32'(STORE_WORDS));

    assign o_status.clear_last    = (r_clr_addr == ADDR_W'(STORE_WORDS - 1));
    assign o_status.root_outside  = (r_root_frame > FRAME_BITS'(TABLE_LIMIT));
    assign o_status.entry_present = r_rdata[PRESENT_BIT];
    assign o_status.next_outside  = (w_entry_frame > FRAME_BITS'(TABLE_LIMIT));

    assign o_phys_addr   = r_pa;
    assign o_status_code = r_status;

    // entry store, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.clear_en) begin
            mem[r_clr_addr] <= '0;
        end else if (w_wr_ok) begin
            mem[ADDR_W'(i_store_index)] <= i_entry_value;
        end
        if (i_cmd.rd_en) begin
            r_rdata <= mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr   <= '0;
            r_root_frame <= '0;
        end else begin
            if (i_cmd.clear_en) begin
                r_clr_addr <= r_clr_addr + ADDR_W'(1);
            end
            if (i_cfg_we) begin
                r_root_frame <= i_cfg_root[PA_W-1:OFFSET_BITS];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_va) begin
            r_va <= i_va;
        end
        if (i_cmd.res_load) begin
            r_pa     <= i_cmd.res_use_frame ? {w_entry_frame, r_va[OFFSET_BITS-1:0]} : '0;
            r_status <= i_cmd.res_status;
        end
    end

endmodule

// ===== src/four_level_page_table_walker.sv =====
// ----------------------------------------------------------------------------
// four_level_page_table_walker
// write word: stored on acceptance; translate word: no new word is taken during its walk of
// four dependent store reads, one level per cycle, then the result
// result registered, valid in the cycle after a write is accepted, else after the step that ends the walk
// reset starts a clearing pass over all STORE_WORDS words that zeroes the store;
// no request word is taken during it, root writes are taken throughout
// ----------------------------------------------------------------------------
module four_level_page_table_walker
    import fltw_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    fltw_item_if.sink        i_item,
    fltw_result_if.source    o_result,
    fltw_cfg_if.sink         i_cfg
);

    t_ctrl_cmd  w_cmd;
    t_dp_status w_dp;
    logic       w_cfg_we;

    // the root register can be written at any time
    assign i_cfg.ready = 1'b1;
    assign w_cfg_we    = i_cfg.valid && i_cfg.ready;

    // sequencer: clearing pass, intake, level stepping, result valid
    fltw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .i_opcode    (i_item.opcode),
        .i_out_ready (o_result.ready),
        .i_dp        (w_dp),
        .o_in_ready  (i_item.ready),
        .o_out_valid (o_result.valid),
        .o_cmd       (w_cmd)
    );

    // store, root table frame, walk addressing and result payload
    fltw_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_store_index (i_item.store_index),
        .i_entry_value (i_item.entry_value),
        .i_va          (i_item.virt_addr),
        .i_cfg_we      (w_cfg_we),
        .i_cfg_root    (i_cfg.root_table_address),
        .o_status      (w_dp),
        .o_phys_addr   (o_result.phys_addr),
        .o_status_code (o_result.status)
    );

endmodule
